// ===== rtl/irfd_pkg.sv =====
`timescale 1ns / 1ps
package irfd_pkg;

	localparam int unsigned TICK_W      = 15;
	localparam int unsigned CODE_W      = 7;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CMD_BITS    = 7;
	localparam int unsigned SHORT_DEV_BITS = 4;
	localparam int unsigned SHORT_LEN   = 13;
	localparam int unsigned LONG_LEN    = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;
	localparam logic [COUNT_W-1:0] LAST_CMD_IDX   = COUNT_W'(CMD_BITS);
	localparam logic [COUNT_W-1:0] FIRST_DEV_IDX  = COUNT_W'(CMD_BITS + 1);
	localparam logic [COUNT_W-1:0] LAST_DATA_IDX  = COUNT_W'(LONG_LEN - 2);
	localparam logic [COUNT_W-1:0] SHORT_LAST_IDX = COUNT_W'(SHORT_LEN - 1);
	localparam logic [COUNT_W-1:0] LONG_LAST_IDX  = COUNT_W'(LONG_LEN - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MARK = 3'd0,
		CFG_ONE_MARK   = 3'd1,
		CFG_ZERO_MARK  = 3'd2,
		CFG_SPACE      = 3'd3,
		CFG_MARGIN     = 3'd4
	} cfg_idx_t;

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		tick_t start_mark_ticks;
		tick_t one_mark_ticks;
		tick_t zero_mark_ticks;
		tick_t space_ticks;
		tick_t margin_ticks;
	} cfg_t;

	typedef struct packed {
		tick_t mark_ticks;
		tick_t space_ticks_in;
		logic  frame_end;
	} sym_t;

	typedef struct packed {
		logic  frame_ok;
		code_t command_code;
		code_t device_code;
		logic  long_frame;
	} res_t;

	typedef struct packed {
		logic start_ok;
		logic is_one;
		logic is_zero;
	} sym_class_t;

	// lo is spec - margin clamped at zero, hi keeps the carry
	function automatic logic in_window(tick_t v, tick_t spec, tick_t margin);
		tick_t             lo;
		logic [TICK_W:0]   hi;
		lo = (spec > margin) ? (spec - margin) : '0;
		hi = {1'b0, spec} + {1'b0, margin};
		return (v > lo) && ({1'b0, v} < hi);
	endfunction

endpackage

// ===== rtl/irfd_stream_if.sv =====
`timescale 1ns / 1ps
interface irfd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/irfd_cfg_regs.sv =====
`timescale 1ns / 1ps
module irfd_cfg_regs
	import irfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  tick_t                cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_mark_ticks <= 15'd2400;
			cfg_q.one_mark_ticks   <= 15'd1200;
			cfg_q.zero_mark_ticks  <= 15'd600;
			cfg_q.space_ticks      <= 15'd600;
			cfg_q.margin_ticks     <= 15'd200;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_MARK: cfg_q.start_mark_ticks <= cfg_wdata;
				CFG_ONE_MARK:   cfg_q.one_mark_ticks   <= cfg_wdata;
				CFG_ZERO_MARK:  cfg_q.zero_mark_ticks  <= cfg_wdata;
				CFG_SPACE:      cfg_q.space_ticks      <= cfg_wdata;
				CFG_MARGIN:     cfg_q.margin_ticks     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/irfd_sym_class.sv =====
`timescale 1ns / 1ps
module irfd_sym_class
	import irfd_pkg::*;
(
	input  cfg_t       cfg,
	input  tick_t      mark_ticks,
	input  tick_t      space_ticks_in,
	output sym_class_t cls
);

	logic space_ok;

	always_comb begin
		space_ok    = in_window(space_ticks_in, cfg.space_ticks, cfg.margin_ticks);
		cls.start_ok = in_window(mark_ticks, cfg.start_mark_ticks, cfg.margin_ticks);
		cls.is_one  = space_ok
			&& in_window(mark_ticks, cfg.one_mark_ticks, cfg.margin_ticks);
		// a mark inside both windows counts as a one
		cls.is_zero = space_ok && !cls.is_one
			&& in_window(mark_ticks, cfg.zero_mark_ticks, cfg.margin_ticks);
	end

endmodule

// ===== rtl/ir_remote_frame_decoder.sv =====
`timescale 1ns / 1ps
// Infrared remote frame decoder: takes one word per measured pulse symbol
// (mark and space ticks plus a frame_end flag) and gives one result word
// when frame_end arrives. Each symbol is registered at the input, classified
// against the timing windows and folded into the frame state, and the result
// sits in an output register. A new symbol word is taken every cycle unless a
// finished result is still waiting on the output and the registered symbol
// would make another. Frames of 13 symbols give 7 command and 4 device bits,
// frames of 16 give 7 and 7; any other length or a symbol outside its window
// gives frame_ok low with all other fields zero. Timing registers are written
// through the cfg port; the user must write them only while no frame is in
// flight, and the block itself does not enforce it.
module ir_remote_frame_decoder
	import irfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  tick_t                cfg_wdata,
	irfd_stream_if.sink          symbol,
	irfd_stream_if.source        result
);

	cfg_t       cfg;
	sym_class_t cls;

	logic             valid_s1;
	sym_t             sym_s1;
	logic             adv;

	logic [COUNT_W-1:0] count_q;
	code_t              cmd_q;
	code_t              dev_q;
	logic               bad_q;

	logic res_valid_q;
	res_t res_q;

	logic [2:0] cmd_pos;
	logic [2:0] dev_pos;
	logic       is_short;
	logic       is_long;
	logic       frame_ok;
	res_t       res_d;

	irfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irfd_sym_class u_class (
		.cfg            (cfg),
		.mark_ticks     (sym_s1.mark_ticks),
		.space_ticks_in (sym_s1.space_ticks_in),
		.cls            (cls)
	);

	// a registered last symbol needs a free output slot
	assign adv = valid_s1 && (!sym_s1.frame_end || !res_valid_q || result.ready);
	assign symbol.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (symbol.ready) begin
			valid_s1 <= symbol.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (symbol.valid && symbol.ready) begin
			sym_s1 <= symbol.data;
		end
	end

	assign cmd_pos = 3'(count_q - 5'd1);
	assign dev_pos = 3'(count_q - FIRST_DEV_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cmd_q   <= '0;
			dev_q   <= '0;
			bad_q   <= 1'b0;
		end else if (adv) begin
			if (sym_s1.frame_end) begin
				count_q <= '0;
				cmd_q   <= '0;
				dev_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				if (count_q == '0) begin
					if (!cls.start_ok) begin
						bad_q <= 1'b1;
					end
				end else if (count_q <= LAST_DATA_IDX) begin
					if (!cls.is_one && !cls.is_zero) begin
						bad_q <= 1'b1;
					end else if (count_q <= LAST_CMD_IDX) begin
						cmd_q[cmd_pos] <= cmd_q[cmd_pos] | cls.is_one;
					end else begin
						dev_q[dev_pos] <= dev_q[dev_pos] | cls.is_one;
					end
				end
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 5'd1;
				end
			end
		end
	end

	always_comb begin
		is_short = (count_q == SHORT_LAST_IDX);
		is_long  = (count_q == LONG_LAST_IDX);
		frame_ok = (is_short || is_long) && !bad_q;
		res_d.frame_ok     = frame_ok;
		res_d.command_code = frame_ok ? cmd_q : '0;
		res_d.long_frame   = frame_ok && is_long;
		if (!frame_ok) begin
			res_d.device_code = '0;
		end else if (is_long) begin
			res_d.device_code = dev_q;
		end else begin
			res_d.device_code = {(CODE_W - SHORT_DEV_BITS)'(0), dev_q[SHORT_DEV_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && sym_s1.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && sym_s1.frame_end) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_clear_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && sym_s1.frame_end) |=> (count_q == '0 && !bad_q && cmd_q == '0 && dev_q == '0))
		else $error("frame state not cleared after result");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.data.frame_ok) |->
		(result.data.command_code == '0 && result.data.device_code == '0
		&& !result.data.long_frame))
		else $error("failed frame carries nonzero fields");

	a_short_device_width: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.frame_ok && !result.data.long_frame) |->
		(result.data.device_code[CODE_W-1:SHORT_DEV_BITS] == '0))
		else $error("short frame device code too wide");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready && valid_s1 && sym_s1.frame_end) |-> !adv)
		else $error("pending result overwritten");

endmodule
